// ===== hdl/svd_pkg.sv =====
// Shared constants for the stream byte-length frame decoder.
// No dependencies; imported by stream_vbyte_decoder.
package svd_pkg;

	localparam int MAX_VALUES = 4096;
	localparam int KEY_DEPTH  = (MAX_VALUES + 3) / 4;
	localparam int KEY_AW     = $clog2(KEY_DEPTH);

	localparam int CNT_W  = 13;
	localparam int BYTE_W = 8;
	localparam int VAL_W  = 32;
	localparam int PART_W = 24;
	localparam int BT_W   = 15;

	localparam logic [1:0] CODE_MASK = 2'h3;

endpackage

// ===== hdl/stream_vbyte_decoder.sv =====
// Frame decoder: key bytes into a key store, data bytes gathered into integers.
// Depends on svd_pkg.
//
// Output: a result appears in the output register in the cycle after its last byte.
// Throughput: one byte per cycle; the input stalls only while the output register
// holds an item that is not taken. The key store is read one key ahead, so its
// registered read never stalls the data bytes.
// Reset (arst_n low): count, progress and output valid clear; key store is not cleared.
module stream_vbyte_decoder
	import svd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CNT_W-1:0]    cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [BYTE_W-1:0]   stream_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VAL_W-1:0]    decoded_value,
	output logic                frame_last,
	output logic [BT_W-1:0]     bytes_consumed
);

	logic [BYTE_W-1:0] key_mem [KEY_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;
	logic [BYTE_W-1:0] cur_key_q;

	logic [CNT_W-1:0]  cnt_q;
	logic [BT_W-1:0]   bytes_taken_q;
	logic [CNT_W-1:0]  values_done_q;
	logic [PART_W-1:0] partial_q;
	logic [1:0]        bytes_in_q;

	logic              out_valid_q;
	logic [VAL_W-1:0]  out_value_q;
	logic              out_last_q;
	logic [BT_W-1:0]   out_bytes_q;

	logic              in_acc;
	logic [CNT_W:0]    key_sum;
	logic [CNT_W-2:0]  key_len;
	logic              key_phase;
	logic              key_we;
	logic [KEY_AW-1:0] key_waddr;
	logic [KEY_AW-1:0] key_raddr;
	logic [1:0]        code;
	logic              emit;
	logic              last;
	logic [CNT_W:0]    done_next;
	logic [BT_W-1:0]   taken_next;
	logic [VAL_W-1:0]  value;

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	assign key_sum   = {1'b0, cnt_q} + (CNT_W+1)'(3);
	assign key_len   = key_sum[CNT_W:2];
	assign key_phase = bytes_taken_q < BT_W'(key_len);
	assign key_we    = in_acc && (cnt_q != '0) && key_phase;
	assign key_waddr = bytes_taken_q[KEY_AW-1:0];

	// The store is always read one key ahead of the group being decoded.
	assign key_raddr = values_done_q[KEY_AW+1:2] + KEY_AW'(1);

	assign code       = cur_key_q[{values_done_q[1:0], 1'b0} +: 2] & CODE_MASK;
	assign emit       = in_acc && (cnt_q != '0) && !key_phase && (bytes_in_q >= code);
	assign done_next  = {1'b0, values_done_q} + (CNT_W+1)'(1);
	assign last       = done_next == {1'b0, cnt_q};
	assign taken_next = bytes_taken_q + BT_W'(1);

	always_comb begin
		case (bytes_in_q)
			2'd0:    value = {{(VAL_W-BYTE_W){1'b0}}, stream_byte};
			2'd1:    value = {{(VAL_W-PART_W){1'b0}}, PART_W'({stream_byte, partial_q[7:0]})};
			2'd2:    value = {{(VAL_W-PART_W){1'b0}}, stream_byte, partial_q[15:0]};
			default: value = {stream_byte, partial_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= stream_byte;
		end
		rd_data_q <= key_mem[key_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			bytes_taken_q <= '0;
			values_done_q <= '0;
			bytes_in_q    <= '0;
			partial_q     <= '0;
			cur_key_q     <= '0;
		end else if (cfg_wr_en) begin
			cnt_q         <= (cfg_wr_data > CNT_W'(MAX_VALUES)) ? CNT_W'(MAX_VALUES) : cfg_wr_data;
			bytes_taken_q <= '0;
			values_done_q <= '0;
			bytes_in_q    <= '0;
			partial_q     <= '0;
		end else if (in_acc && (cnt_q != '0)) begin
			if (key_phase) begin
				bytes_taken_q <= taken_next;
				// The first key of the frame goes straight to the current-key register.
				if (bytes_taken_q == '0) begin
					cur_key_q <= stream_byte;
				end
			end else if (!emit) begin
				bytes_taken_q <= taken_next;
				bytes_in_q    <= bytes_in_q + 2'd1;
				case (bytes_in_q)
					2'd0:    partial_q[7:0]   <= stream_byte;
					2'd1:    partial_q[15:8]  <= stream_byte;
					default: partial_q[23:16] <= stream_byte;
				endcase
			end else begin
				partial_q  <= '0;
				bytes_in_q <= '0;
				if (last) begin
					bytes_taken_q <= '0;
					values_done_q <= '0;
				end else begin
					bytes_taken_q <= taken_next;
					values_done_q <= done_next[CNT_W-1:0];
					// Crossing into the next group of four takes the prefetched key.
					if (values_done_q[1:0] == 2'd3) begin
						cur_key_q <= rd_data_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q <= value;
			out_last_q  <= last;
			out_bytes_q <= taken_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign decoded_value  = out_value_q;
	assign frame_last     = out_last_q;
	assign bytes_consumed = out_bytes_q;

	a_zero_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (bytes_taken_q == '0) && (values_done_q == '0))
		else $error("progress moved with a zero count");

	a_done_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(values_done_q < cnt_q) || (values_done_q == '0))
		else $error("values_done reached the frame count");

	a_key_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> !emit)
		else $error("result produced on a key byte");

	a_rearm_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last && !cfg_wr_en) |=> (bytes_taken_q == '0) && (values_done_q == '0))
		else $error("frame not rearmed after its last item");

endmodule
